>>> hw/rtl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// Holds command, result and sequencer types; no dependencies.
`default_nettype none

package fba_pkg;

    // Field widths of the command and result beats.
    localparam int FRAME_W = 20;
    localparam int OP_W    = 3;

    // The map is stored as 64-bit words, one bit per frame.
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;

    // Operation codes; codes above OP_ALLOC do nothing.
    localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_USED = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] frame_index;
    } fba_cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               frame_is_free;
        logic               found;
    } fba_result_t;

    // Status returned by the shared word unit to the sequencer.
    typedef struct packed {
        logic              bit_val;
        logic              any_set;
        logic [BIT_W-1:0]  low_pos;
        logic [WORD_W-1:0] new_word;
    } fba_unit_res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } fba_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: sequencer, map memory and word unit.
// Depends on fba_pkg, fba_map_ram and fba_bit_unit.
//
//   Channel   Ports                 Direction  Beat taken when
//   command   start, cmd, busy      in         start && !busy
//   result    done, result          out        done (one cycle, no stall)
//
// Mark and query beats first read the map word, then test or rewrite it.
// Out-of-map marks and queries, unknown codes and a find on an empty map
// answer in the cycle after the beat. Find and allocate read one 64-bit word
// at a time, scanning upward from the low-water mark below which every word
// is known to be zero; the single memory read port sets that pace. After
// reset a clearing pass zeroes all (MAP_BYTES+7)/8 words (16384 by default)
// of the memory while busy is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int MAP_BYTES = 131072
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire fba_cmd_t cmd,
    output logic          busy,
    output logic          done,
    output fba_result_t   result
);

    localparam int DEPTH = (MAP_BYTES + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);
    localparam logic [AW:0]   EMPTY     = (AW + 1)'(DEPTH);
    localparam logic [17:0]   BYTE_LIM  = 18'(MAP_BYTES);

    fba_state_t state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [FRAME_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW:0]        hint_reg, hint_next;
    logic               done_reg, done_next;
    fba_result_t        res_reg, res_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic          unit_use_low;
    logic          unit_set;
    fba_unit_res_t unit_res;

    logic          in_map;
    logic [AW-1:0] cmd_word;
    logic [AW-1:0] held_word;

    fba_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_bit_unit u_unit (
        .word    (ram_rdata),
        .bit_sel (idx_reg[BIT_W-1:0]),
        .use_low (unit_use_low),
        .set_bit (unit_set),
        .res     (unit_res)
    );

    // Frame-to-word mapping and the map range check.
    assign in_map    = {1'b0, cmd.frame_index[FRAME_W-1:3]} < BYTE_LIM;
    assign cmd_word  = cmd.frame_index[BIT_W +: AW];
    assign held_word = idx_reg[BIT_W +: AW];

    // Sequencer state and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            hint_reg  <= EMPTY;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
    end

    // Next state, memory control and result formation.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        scan_next    = scan_reg;
        clr_next     = clr_reg;
        hint_next    = hint_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = scan_reg;
        ram_wdata    = unit_res.new_word;
        ram_raddr    = scan_reg;
        unit_use_low = 1'b0;
        unit_set     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.operation;
                    idx_next = cmd.frame_index;
                    // Default answer: echo the frame, nothing found.
                    res_next.frame_number  = cmd.frame_index;
                    res_next.frame_is_free = 1'b0;
                    res_next.found         = 1'b0;
                    unique case (cmd.operation)
                        OP_MARK_FREE, OP_MARK_USED, OP_QUERY:
                        begin
                            if (in_map)
                            begin
                                ram_raddr  = cmd_word;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_FIND, OP_ALLOC:
                        begin
                            if (hint_reg == EMPTY)
                            begin
                                res_next.frame_number = '0;
                                done_next             = 1'b1;
                            end
                            else
                            begin
                                ram_raddr  = hint_reg[AW-1:0];
                                scan_next  = hint_reg[AW-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                unit_set  = (op_reg == OP_MARK_FREE);
                done_next = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_QUERY)
                begin
                    res_next.frame_is_free = unit_res.bit_val;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = held_word;
                    // A freed frame may lower the low-water mark.
                    if ((op_reg == OP_MARK_FREE) && ({1'b0, held_word} < hint_reg))
                    begin
                        hint_next = {1'b0, held_word};
                    end
                end
            end

            ST_SCAN:
            begin
                unit_use_low = 1'b1;
                if (unit_res.any_set)
                begin
                    ram_we    = (op_reg == OP_ALLOC);
                    ram_waddr = scan_reg;
                    hint_next = {1'b0, scan_reg};
                    res_next.frame_number = FRAME_W'({scan_reg, unit_res.low_pos});
                    res_next.found        = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (scan_reg == LAST_WORD)
                begin
                    hint_next             = EMPTY;
                    res_next.frame_number = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                    ram_raddr = scan_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fba_map_ram.sv
// Word-wide storage for the free-frame bitmap.
// One write port and one registered read port; uses fba_pkg.
`default_nettype none

module fba_map_ram
    import fba_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/fba_bit_unit.sv
// Shared word unit: bit test, bit set or clear, and lowest-set-bit search.
// Works on one 64-bit map word per cycle; uses fba_pkg.
`default_nettype none

module fba_bit_unit
    import fba_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [BIT_W-1:0]  bit_sel,
    input  wire logic              use_low,
    input  wire logic              set_bit,
    output fba_unit_res_t          res
);

    logic [WORD_W-1:0] low_onehot;
    logic [BIT_W-1:0]  low_pos;
    logic [BIT_W-1:0]  sel;
    logic [WORD_W-1:0] mask;

    // Isolate the lowest set bit, then encode its position.
    always_comb
    begin
        low_onehot = word & (~word + WORD_W'(1));
        low_pos    = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low_onehot[i])
            begin
                low_pos = low_pos | BIT_W'(i);
            end
        end
    end

    // Modify the selected bit, either the addressed one or the lowest set one.
    always_comb
    begin
        sel  = use_low ? low_pos : bit_sel;
        mask = WORD_W'(1) << sel;
        res.bit_val  = word[sel];
        res.any_set  = |word;
        res.low_pos  = low_pos;
        res.new_word = set_bit ? (word | mask) : (word & ~mask);
    end

endmodule

`default_nettype wire

>>> hw/rtl/fba_checker.sv
// Port-level checks for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator.
`default_nettype none

module fba_checker
    import fba_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire fba_result_t result
);

    // A result beat only appears once the block is ready again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An accepted command either keeps the block busy or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command was dropped");

    // Busy only rises because a command beat was taken.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // A query answer and a found frame never come together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.frame_is_free && result.found))
        else $error("free and found both set");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for frame_bitmap_allocator: directed and random command beats.
// Depends on fba_pkg and the frame_bitmap_allocator RTL; predicts each result in-line.
`timescale 1ns / 1ps

module tb;
    import fba_pkg::*;

    localparam int MAP_BYTES   = 131072;
    localparam int MAP_FRAMES  = MAP_BYTES * 8;
    localparam int RANDOM_CMDS = 1100;
    localparam int SETTLE_CYC  = 20;

    // One pending command beat, or a marker that holds the sender until idle.
    typedef struct {
        fba_cmd_t    cmd;
        int unsigned gap;
        bit          drain;
    } cmd_slot_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    fba_cmd_t    cmd   = '0;
    logic        busy;
    logic        done;
    fba_result_t result;

    cmd_slot_t   cmd_queue[$];
    fba_result_t expected_results[$];
    bit          free_frames[int unsigned];

    cmd_slot_t   next_slot;
    logic        cmd_taken     = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned queued_cmds   = 0;
    int unsigned accepted_cmds = 0;
    int unsigned fail_count    = 0;

    frame_bitmap_allocator #(
        .MAP_BYTES(MAP_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mirror of the free map: a frame is free when its key is present, so the
    // lowest free frame is simply the first key.
    function automatic fba_result_t predict_frame_op(fba_cmd_t c);
        fba_result_t r;
        int unsigned lowest;
        bit          in_map;
        in_map          = int'(c.frame_index) < MAP_FRAMES;
        r.frame_number  = c.frame_index;
        r.frame_is_free = 1'b0;
        r.found         = 1'b0;
        case (c.operation)
            OP_MARK_FREE:
                if (in_map) free_frames[c.frame_index] = 1'b1;
            OP_MARK_USED:
                if (in_map) free_frames.delete(c.frame_index);
            OP_QUERY:
                r.frame_is_free = in_map && free_frames.exists(c.frame_index);
            OP_FIND, OP_ALLOC:
            begin
                r.frame_number = '0;
                if (free_frames.first(lowest))
                begin
                    r.found        = 1'b1;
                    r.frame_number = lowest[FRAME_W-1:0];
                    if (c.operation == OP_ALLOC) free_frames.delete(lowest);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_cmd(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frame, int unsigned gap);
        cmd_slot_t s;
        s.cmd.operation   = op;
        s.cmd.frame_index = frame;
        s.gap             = gap;
        s.drain           = 1'b0;
        cmd_queue.push_back(s);
        queued_cmds++;
    endtask

    task automatic add_drain();
        cmd_slot_t s;
        s.cmd   = '0;
        s.gap   = 0;
        s.drain = 1'b1;
        cmd_queue.push_back(s);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Frames cluster low so scans stay short; a few land anywhere or near the top.
    function automatic logic [FRAME_W-1:0] pick_frame();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return FRAME_W'($urandom());
        if (r == 1) return FRAME_W'({FRAME_W{1'b1}} - $urandom_range(0, 63));
        return FRAME_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_MARK_FREE;
        if (r < 38) return OP_MARK_USED;
        if (r < 56) return OP_QUERY;
        if (r < 68) return OP_FIND;
        if (r < 92) return OP_ALLOC;
        return OP_W'($urandom_range(OP_ALLOC + 1, {OP_W{1'b1}}));
    endfunction

    // Driver: presents the next queued beat at the falling edge and holds it
    // until it has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !cmd_taken)
            ;
        else if (gap_left != 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (cmd_queue.size() == 0)
            start <= 1'b0;
        else if (cmd_queue[0].drain)
        begin
            start <= 1'b0;
            if (expected_results.size() == 0) void'(cmd_queue.pop_front());
        end
        else
        begin
            next_slot = cmd_queue.pop_front();
            cmd      <= next_slot.cmd;
            start    <= 1'b1;
            gap_left <= next_slot.gap;
        end
    end

    // Monitor: checks each result beat against the oldest prediction, then
    // predicts for a command taken at the same edge.
    always @(posedge clk)
    begin
        fba_result_t want;
        if (rst_n)
        begin
            cmd_taken <= start && !busy;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no command outstanding: frame_number %0d",
                           result.frame_number);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.frame_number !== want.frame_number)
                    begin
                        $error("frame_number: expected %0d, got %0d",
                               want.frame_number, result.frame_number);
                        fail_count++;
                    end
                    if (result.frame_is_free !== want.frame_is_free)
                    begin
                        $error("frame_is_free: expected %0d, got %0d",
                               want.frame_is_free, result.frame_is_free);
                        fail_count++;
                    end
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, result.found);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_frame_op(cmd));
                accepted_cmds++;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned burst;
        // Empty map: nothing is free, find and allocate come back empty.
        add_cmd(OP_QUERY, '0, 0);
        add_cmd(OP_QUERY, {FRAME_W{1'b1}}, 1);
        add_cmd(OP_FIND, 20'h12345, 0);
        add_cmd(OP_ALLOC, {FRAME_W{1'b1}}, 2);
        // Only the top frame free: the low-water mark moves to the top word.
        add_cmd(OP_MARK_FREE, {FRAME_W{1'b1}}, 0);
        add_cmd(OP_QUERY, {FRAME_W{1'b1}}, 0);
        add_cmd(OP_FIND, '0, 0);
        add_cmd(OP_ALLOC, '0, 0);
        add_cmd(OP_QUERY, {FRAME_W{1'b1}}, 0);
        // Frame zero is an ordinary frame.
        add_cmd(OP_MARK_FREE, '0, 0);
        add_cmd(OP_FIND, 20'hFFFFF, 0);
        add_cmd(OP_ALLOC, 20'h00001, 0);
        add_cmd(OP_FIND, '0, 3);
        // Repeated marks on the same frame.
        add_cmd(OP_MARK_USED, 20'h00007, 0);
        add_cmd(OP_MARK_FREE, 20'hAAAAA, 0);
        add_cmd(OP_MARK_FREE, 20'hAAAAA, 0);
        add_cmd(OP_MARK_FREE, 20'h55555, 0);
        add_cmd(OP_QUERY, 20'h55555, 0);
        add_cmd(OP_MARK_USED, 20'h55555, 0);
        add_cmd(OP_QUERY, 20'h55555, 0);
        add_cmd(OP_QUERY, 20'hAAAAA, 0);
        // Unknown codes change nothing and echo the frame.
        add_cmd(OP_W'(OP_ALLOC + 1), 20'hFFFFF, 0);
        add_cmd({OP_W{1'b1}}, 20'h5A5A5, 0);
        add_cmd(OP_ALLOC, '0, 0);
        add_drain();

        // Random part: stretches without gaps alternate with gapped stretches,
        // and the sender drains the block once halfway through.
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            burst = (i / 100) % 3;
            add_cmd(pick_op(), pick_frame(), (burst == 1) ? 0 : pick_gap());
            if (i == RANDOM_CMDS / 2) add_drain();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cmds != queued_cmds || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the clearing pass plus every long scan this stimulus can cause.
    initial
    begin
        #1_000_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fba_pkg.sv
hw/rtl/fba_map_ram.sv
hw/rtl/fba_bit_unit.sv
hw/rtl/frame_bitmap_allocator.sv
hw/rtl/fba_checker.sv
bench/tb.sv
